>>> rtl/core/aapr_pkg.sv
// aapr_pkg: shared types and constants of the axis-angle point rotation unit.
// No dependencies; imported by aapr_matrix, aapr_lane and the top level.
package aapr_pkg;

	// configuration port
	localparam int CFG_IDX_W = 4;

	localparam logic [CFG_IDX_W-1:0] REG_COS      = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIN      = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_AXIS_X   = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_AXIS_Y   = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_AXIS_Z   = 4'd7;

	// matrix derivation sequence: 3 sine products, then 6 symmetric pairs
	// of (n_i*n_j, then *(1-cos))
	localparam int NUM_STEPS = 15;
	localparam int STEP_W    = 4;
	localparam int SN_STEPS  = 3;

	typedef enum logic [1:0] {
		MX_IDLE,
		MX_MUL,
		MX_RND
	} mx_state_t;

	typedef enum logic [1:0] {
		OP_SN,
		OP_NN,
		OP_T
	} op_t;

	// per-stage load enables handed to each row lane
	typedef struct packed {
		logic en_s2;
		logic en_s3;
		logic en_s4;
	} lane_ctl_t;

	// upper-triangle pair order: 00 01 02 11 12 22
	function automatic logic [1:0] pair_i(input logic [2:0] p);
		logic [1:0] r;
		unique case (p)
			3'd0, 3'd1, 3'd2: r = 2'd0;
			3'd3, 3'd4:       r = 2'd1;
			default:          r = 2'd2;
		endcase
		return r;
	endfunction

	function automatic logic [1:0] pair_j(input logic [2:0] p);
		logic [1:0] r;
		unique case (p)
			3'd0:       r = 2'd0;
			3'd1:       r = 2'd1;
			3'd2:       r = 2'd2;
			3'd3:       r = 2'd1;
			3'd4:       r = 2'd2;
			default:    r = 2'd2;
		endcase
		return r;
	endfunction

endpackage

>>> rtl/core/axis_angle_point_rotation_unit.sv
// axis_angle_point_rotation_unit: top level of the 3D point rotation block.
// Depends on aapr_pkg, aapr_matrix and aapr_lane.
//
// Rotates a stream of Q16.16 points about an axis through a programmable
// center: out = c + M*(p - c), rounded half up and clamped to COORD_BITS,
// with 'saturated' set when any coordinate clamps. M is the Rodrigues matrix
// cos*I + (1-cos)*n*n^T + sin*[n]x built from the Q2.30 cos, sin and unit
// axis registers; software supplies normalized values. Throughput is one
// point per clock while the output is not stalled and the matrix is not
// being derived: three row lanes each hold three multipliers, and a point
// moves through five register stages (center subtract, multiply, partial
// sums, final sum with round/clamp, output register). A finished beat
// waiting in the output register does not block intake while the lanes
// have a free stage. Every register write restarts the matrix derivation,
// which runs on one shared multiplier for 15 products, each taking a
// multiply state and then a round state: in_ready stays low until it ends
// (and in the write cycle itself). Write registers only when no points are
// in flight. Indexes above 7 are ignored.
module axis_angle_point_rotation_unit #(
	parameter int COORD_BITS     = 32,
	parameter int COEF_FRAC_BITS = 30
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration
	input  logic                                cfg_wr_en,
	input  logic [aapr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [((COORD_BITS > COEF_FRAC_BITS + 2) ?
	              COORD_BITS : COEF_FRAC_BITS + 2)-1:0] cfg_data,
	// input points
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [COORD_BITS-1:0]        px_in,
	input  logic signed [COORD_BITS-1:0]        py_in,
	input  logic signed [COORD_BITS-1:0]        pz_in,
	input  logic                                last_point_in,
	// rotated points
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [COORD_BITS-1:0]        px_out,
	output logic signed [COORD_BITS-1:0]        py_out,
	output logic signed [COORD_BITS-1:0]        pz_out,
	output logic                                last_point_out,
	output logic                                saturated
);
	import aapr_pkg::*;

	localparam int F  = COEF_FRAC_BITS;
	localparam int CW = COEF_FRAC_BITS + 2;
	localparam int DW = COORD_BITS + 1;

	localparam logic signed [CW-1:0] ONE = CW'(1) <<< F;

	// configuration registers
	logic signed [CW-1:0]         cos_q, sin_q;
	logic signed [CW-1:0]         axis_q [3];
	logic signed [COORD_BITS-1:0] ctr_q  [3];
	logic                         cfg_hit;

	// matrix
	logic                 mx_busy;
	logic signed [CW-1:0] mat      [9];
	logic signed [CW-1:0] row_coef [3][3];

	// pipeline control
	logic      v_s1, v_s2, v_s3, v_s4;
	logic      last_s1, last_s2, last_s3, last_s4;
	logic      rdy_out, rdy1, rdy2, rdy3, rdy4;
	logic      accept;
	lane_ctl_t lane_ctl;

	logic signed [COORD_BITS-1:0] point [3];
	logic signed [DW-1:0]         d_s1  [3];

	logic signed [COORD_BITS-1:0] lane_coord [3];
	logic [2:0]                   lane_clip;

	// output register
	logic                         out_valid_q, last_q, sat_q;
	logic signed [COORD_BITS-1:0] coord_q [3];

	//--------------------------------------------------------------------
	// Register file; any valid write kicks off a fresh derivation
	//--------------------------------------------------------------------
	assign cfg_hit = cfg_wr_en && (cfg_index <= REG_AXIS_Z);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_q     <= ONE;
			sin_q     <= '0;
			ctr_q[0]  <= '0;
			ctr_q[1]  <= '0;
			ctr_q[2]  <= '0;
			axis_q[0] <= '0;
			axis_q[1] <= '0;
			axis_q[2] <= ONE;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_COS:      cos_q     <= cfg_data[CW-1:0];
				REG_SIN:      sin_q     <= cfg_data[CW-1:0];
				REG_CENTER_X: ctr_q[0]  <= cfg_data[COORD_BITS-1:0];
				REG_CENTER_Y: ctr_q[1]  <= cfg_data[COORD_BITS-1:0];
				REG_CENTER_Z: ctr_q[2]  <= cfg_data[COORD_BITS-1:0];
				REG_AXIS_X:   axis_q[0] <= cfg_data[CW-1:0];
				REG_AXIS_Y:   axis_q[1] <= cfg_data[CW-1:0];
				REG_AXIS_Z:   axis_q[2] <= cfg_data[CW-1:0];
				default: ;
			endcase
		end
	end

	aapr_matrix #(
		.COEF_FRAC_BITS(COEF_FRAC_BITS)
	) u_matrix (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cfg_hit),
		.cos_c (cos_q),
		.sin_c (sin_q),
		.axis  (axis_q),
		.busy  (mx_busy),
		.mat   (mat)
	);

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int k = 0; k < 3; k++) begin
				row_coef[r][k] = mat[3 * r + k];
			end
		end
	end

	//--------------------------------------------------------------------
	// Elastic pipeline: a stage loads when empty or when its successor
	// moves, so bubbles collapse behind a stalled output beat.
	//--------------------------------------------------------------------
	always_comb begin
		rdy_out  = !out_valid_q || out_ready;
		rdy4     = !v_s4 || rdy_out;
		rdy3     = !v_s3 || rdy4;
		rdy2     = !v_s2 || rdy3;
		rdy1     = !v_s1 || rdy2;
		in_ready = rdy1 && !mx_busy && !cfg_wr_en;
		accept   = in_valid && in_ready;

		lane_ctl.en_s2 = rdy2;
		lane_ctl.en_s3 = rdy3;
		lane_ctl.en_s4 = rdy4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy1)    v_s1        <= accept;
			if (rdy2)    v_s2        <= v_s1;
			if (rdy3)    v_s3        <= v_s2;
			if (rdy4)    v_s4        <= v_s3;
			if (rdy_out) out_valid_q <= v_s4;
		end
	end

	// stage 1: offset from the rotation center (one extra bit, exact)
	assign point[0] = px_in;
	assign point[1] = py_in;
	assign point[2] = pz_in;

	always_ff @(posedge clk) begin
		if (rdy1) begin
			for (int k = 0; k < 3; k++) begin
				d_s1[k] <= DW'(point[k]) - DW'(ctr_q[k]);
			end
			last_s1 <= last_point_in;
		end
		if (rdy2) last_s2 <= last_s1;
		if (rdy3) last_s3 <= last_s2;
		if (rdy4) last_s4 <= last_s3;
	end

	// stages 2..4: one lane per output coordinate
	for (genvar r = 0; r < 3; r++) begin : g_lane
		aapr_lane #(
			.COORD_BITS    (COORD_BITS),
			.COEF_FRAC_BITS(COEF_FRAC_BITS)
		) u_lane (
			.clk   (clk),
			.ctl   (lane_ctl),
			.coef  (row_coef[r]),
			.delta (d_s1),
			.center(ctr_q[r]),
			.coord (lane_coord[r]),
			.clip  (lane_clip[r])
		);
	end

	// merge: collect the three lanes into one output beat
	always_ff @(posedge clk) begin
		if (rdy_out) begin
			coord_q[0] <= lane_coord[0];
			coord_q[1] <= lane_coord[1];
			coord_q[2] <= lane_coord[2];
			last_q     <= last_s4;
			sat_q      <= |lane_clip;
		end
	end

	assign out_valid      = out_valid_q;
	assign px_out         = coord_q[0];
	assign py_out         = coord_q[1];
	assign pz_out         = coord_q[2];
	assign last_point_out = last_q;
	assign saturated      = sat_q;

endmodule

>>> rtl/core/aapr_matrix.sv
// aapr_matrix: derives the Rodrigues rotation matrix with one shared multiplier.
// Depends on aapr_pkg (state/op enums, step constants, pair decode).
module aapr_matrix #(
	parameter int COEF_FRAC_BITS = 30
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic signed [COEF_FRAC_BITS+1:0] cos_c,
	input  logic signed [COEF_FRAC_BITS+1:0] sin_c,
	input  logic signed [COEF_FRAC_BITS+1:0] axis [3],
	output logic                            busy,
	output logic signed [COEF_FRAC_BITS+1:0] mat [9]
);
	import aapr_pkg::*;

	localparam int F   = COEF_FRAC_BITS;
	localparam int CW  = COEF_FRAC_BITS + 2;
	localparam int PW  = 2 * CW;
	localparam int RW  = PW + 1;
	localparam int OW  = CW + 1;
	localparam int EW  = CW + 2;

	localparam logic signed [RW-1:0] RND_HALF = RW'(1) <<< (F - 1);
	localparam logic signed [RW-1:0] RMAX     = (RW'(1) <<< (CW - 1)) - RW'(1);
	localparam logic signed [RW-1:0] RMIN     = -(RW'(1) <<< (CW - 1));
	localparam logic signed [OW-1:0] OMAX     = (OW'(1) <<< (CW - 1)) - OW'(1);
	localparam logic signed [OW-1:0] OMIN     = -(OW'(1) <<< (CW - 1));
	localparam logic signed [EW-1:0] EMAX     = (EW'(1) <<< (CW - 1)) - EW'(1);
	localparam logic signed [EW-1:0] EMIN     = -(EW'(1) <<< (CW - 1));
	localparam logic signed [CW-1:0] ONE      = CW'(1) <<< F;

	mx_state_t state_q, state_nxt;
	logic [STEP_W-1:0] step_q;
	logic              mul_en, rnd_en, last_step;

	logic signed [CW-1:0] mat_q [9];
	logic signed [CW-1:0] sn_q  [3];
	logic signed [CW-1:0] nn_q;
	logic signed [PW-1:0] prod_q;

	// step decode
	op_t               op;
	logic [STEP_W-1:0] pstep;
	logic [2:0]        pair;
	logic [1:0]        pi, pj, sk;
	logic [3:0]        idx_ij, idx_ji;

	logic signed [OW-1:0] omc_w;
	logic signed [CW-1:0] omc;
	logic signed [CW-1:0] op_a, op_b;
	logic signed [RW-1:0] rnd, rq;
	logic signed [CW-1:0] rs;
	logic signed [EW-1:0] u, e1, e2;
	logic signed [CW-1:0] e1_s, e2_s;

	assign last_step = (step_q == STEP_W'(NUM_STEPS - 1));

	always_comb begin
		pstep = step_q - STEP_W'(SN_STEPS);
		pair  = pstep[3:1];
		pi    = pair_i(pair);
		pj    = pair_j(pair);
		sk    = 2'd3 - pi - pj;
		if (step_q < STEP_W'(SN_STEPS)) begin
			op = OP_SN;
		end else if (pstep[0]) begin
			op = OP_T;
		end else begin
			op = OP_NN;
		end
		idx_ij = 4'({2'b00, pi} * 4'd3) + 4'({2'b00, pj});
		idx_ji = 4'({2'b00, pj} * 4'd3) + 4'({2'b00, pi});
	end

	// 1 - cos, saturated
	always_comb begin
		omc_w = (OW'(1) <<< F) - OW'(cos_c);
		if (omc_w > OMAX) begin
			omc = OMAX[CW-1:0];
		end else if (omc_w < OMIN) begin
			omc = OMIN[CW-1:0];
		end else begin
			omc = omc_w[CW-1:0];
		end
	end

	always_comb begin
		unique case (op)
			OP_SN: begin
				op_a = sin_c;
				op_b = axis[step_q[1:0]];
			end
			OP_NN: begin
				op_a = axis[pi];
				op_b = axis[pj];
			end
			default: begin
				op_a = nn_q;
				op_b = omc;
			end
		endcase
	end

	// round half up at F, saturate to coefficient width
	always_comb begin
		rnd = RW'(prod_q) + RND_HALF;
		rq  = rnd >>> F;
		if (rq > RMAX) begin
			rs = RMAX[CW-1:0];
		end else if (rq < RMIN) begin
			rs = RMIN[CW-1:0];
		end else begin
			rs = rq[CW-1:0];
		end
	end

	// add cos on the diagonal, +/- sin*n_k off it
	always_comb begin
		if (pi == pj) begin
			u = EW'(cos_c);
		end else if ((pj - pi) == 2'd1) begin
			u = -EW'(sn_q[sk]);
		end else begin
			u = EW'(sn_q[sk]);
		end
		e1 = EW'(rs) + u;
		e2 = EW'(rs) - u;
		if (e1 > EMAX) begin
			e1_s = EMAX[CW-1:0];
		end else if (e1 < EMIN) begin
			e1_s = EMIN[CW-1:0];
		end else begin
			e1_s = e1[CW-1:0];
		end
		if (e2 > EMAX) begin
			e2_s = EMAX[CW-1:0];
		end else if (e2 < EMIN) begin
			e2_s = EMIN[CW-1:0];
		end else begin
			e2_s = e2[CW-1:0];
		end
	end

	always_comb begin
		state_nxt = state_q;
		if (start) begin
			state_nxt = MX_MUL;
		end else begin
			unique case (state_q)
				MX_IDLE: state_nxt = MX_IDLE;
				MX_MUL:  state_nxt = MX_RND;
				MX_RND:  state_nxt = last_step ? MX_IDLE : MX_MUL;
				default: state_nxt = MX_IDLE;
			endcase
		end
	end

	always_comb begin
		mul_en = 1'b0;
		rnd_en = 1'b0;
		busy   = 1'b1;
		unique case (state_q)
			MX_IDLE: busy   = 1'b0;
			MX_MUL:  mul_en = 1'b1;
			MX_RND:  rnd_en = !start;
			default: busy   = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MX_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_nxt;
			if (start) begin
				step_q <= '0;
			end else if (rnd_en) begin
				step_q <= step_q + STEP_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_q <= PW'(op_a) * PW'(op_b);
		end
		if (rnd_en && op == OP_SN) begin
			sn_q[step_q[1:0]] <= rs;
		end
		if (rnd_en && op == OP_NN) begin
			nn_q <= rs;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) begin
				mat_q[i] <= (i % 4 == 0) ? ONE : '0;
			end
		end else if (rnd_en && op == OP_T) begin
			mat_q[idx_ij] <= e1_s;
			if (pi != pj) begin
				mat_q[idx_ji] <= e2_s;
			end
		end
	end

	assign mat = mat_q;

endmodule

>>> rtl/core/aapr_lane.sv
// aapr_lane: one matrix row applied to a centered point, rounded and clamped.
// Depends on aapr_pkg (lane_ctl_t); one instance per output coordinate.
module aapr_lane #(
	parameter int COORD_BITS     = 32,
	parameter int COEF_FRAC_BITS = 30
) (
	input  logic                             clk,
	input  aapr_pkg::lane_ctl_t              ctl,
	input  logic signed [COEF_FRAC_BITS+1:0] coef [3],
	input  logic signed [COORD_BITS:0]       delta [3],
	input  logic signed [COORD_BITS-1:0]     center,
	output logic signed [COORD_BITS-1:0]     coord,
	output logic                             clip
);
	import aapr_pkg::*;

	localparam int F  = COEF_FRAC_BITS;
	localparam int CW = COEF_FRAC_BITS + 2;
	localparam int DW = COORD_BITS + 1;
	localparam int PW = CW + DW;
	localparam int SW = PW + 1;
	localparam int AW = PW + 2;

	localparam logic signed [SW-1:0] HALF = SW'(1) <<< (F - 1);
	localparam logic signed [AW-1:0] CMAX = (AW'(1) <<< (COORD_BITS - 1)) - AW'(1);
	localparam logic signed [AW-1:0] CMIN = -(AW'(1) <<< (COORD_BITS - 1));

	logic signed [PW-1:0]         prod_s2 [3];
	logic signed [SW-1:0]         sa_s3, sb_s3;
	logic signed [AW-1:0]         acc, q;
	logic signed [COORD_BITS-1:0] coord_s4;
	logic                         clip_s4;

	always_ff @(posedge clk) begin
		if (ctl.en_s2) begin
			for (int k = 0; k < 3; k++) begin
				prod_s2[k] <= PW'(coef[k]) * PW'(delta[k]);
			end
		end
		if (ctl.en_s3) begin
			sa_s3 <= SW'(prod_s2[0]) + SW'(prod_s2[1]);
			sb_s3 <= SW'(prod_s2[2]) + (SW'(center) <<< F) + HALF;
		end
		if (ctl.en_s4) begin
			coord_s4 <= (q > CMAX) ? CMAX[COORD_BITS-1:0] :
			            (q < CMIN) ? CMIN[COORD_BITS-1:0] : q[COORD_BITS-1:0];
			clip_s4  <= (q > CMAX) || (q < CMIN);
		end
	end

	always_comb begin
		acc = AW'(sa_s3) + AW'(sb_s3);
		q   = acc >>> F;
	end

	assign coord = coord_s4;
	assign clip  = clip_s4;

endmodule

>>> tb/sv/point_rotation_check_pkg.sv
`timescale 1ns / 1ps
// point_rotation_check_pkg: scoreboard for the axis-angle point rotation unit.
// Holds a shadow of the registers and the rotation matrix. Imports aapr_pkg.
package point_rotation_check_pkg;
	import aapr_pkg::*;

	localparam int FRAC = 30;
	localparam logic signed [127:0] HALF_LSB = 128'sd1 <<< (FRAC - 1);
	localparam logic signed [127:0] ONE_COEF = 128'sd1 <<< FRAC;
	localparam logic signed [127:0] LIM_HI   = 128'sh7fff_ffff;
	localparam logic signed [127:0] LIM_LO   = -128'sh8000_0000;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic               last;
		logic               sat;
	} rotated_point_t;

	class rotation_scoreboard;
		logic signed [31:0] cos_q;
		logic signed [31:0] sin_q;
		logic signed [31:0] axis_q [3];
		logic signed [31:0] center_q [3];
		logic signed [31:0] mat [9];
		rotated_point_t     rotated_q [$];
		int unsigned        errors;

		function new();
			cos_q = ONE_COEF[31:0];
			sin_q = '0;
			axis_q = '{32'sd0, 32'sd0, ONE_COEF[31:0]};
			center_q = '{32'sd0, 32'sd0, 32'sd0};
			errors = 0;
			rebuild_matrix();
		endfunction

		function logic signed [127:0] wide(input logic signed [31:0] v);
			return v;
		endfunction

		function logic signed [31:0] clamp32(input logic signed [127:0] v);
			if (v > LIM_HI)
				return LIM_HI[31:0];
			if (v < LIM_LO)
				return LIM_LO[31:0];
			return v[31:0];
		endfunction

		// round half up at bit FRAC, then clamp
		function logic signed [31:0] round_clamp(input logic signed [127:0] acc,
				output bit clipped);
			logic signed [127:0] r;
			r = (acc + HALF_LSB) >>> FRAC;
			clipped = (r > LIM_HI) || (r < LIM_LO);
			return clamp32(r);
		endfunction

		function logic signed [31:0] coef_mul(input logic signed [31:0] a,
				input logic signed [31:0] b);
			bit unused;
			return round_clamp(wide(a) * wide(b), unused);
		endfunction

		// cos*I + (1-cos)*n*n^T + sin*[n]x, with saturation at each product
		function void rebuild_matrix();
			logic signed [31:0]  omc;
			logic signed [31:0]  t;
			logic signed [31:0]  sn [3];
			logic signed [127:0] skew [9];
			logic signed [127:0] e;
			omc = clamp32(ONE_COEF - wide(cos_q));
			for (int k = 0; k < 3; k++)
				sn[k] = coef_mul(sin_q, axis_q[k]);
			skew[0] = 0;             skew[1] = -wide(sn[2]); skew[2] = wide(sn[1]);
			skew[3] = wide(sn[2]);   skew[4] = 0;            skew[5] = -wide(sn[0]);
			skew[6] = -wide(sn[1]);  skew[7] = wide(sn[0]);  skew[8] = 0;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					t = coef_mul(coef_mul(axis_q[i], axis_q[j]), omc);
					e = wide(t) + skew[i * 3 + j] + ((i == j) ? wide(cos_q) : 128'sd0);
					mat[i * 3 + j] = clamp32(e);
				end
			end
		endfunction

		function void write_register(input logic [CFG_IDX_W-1:0] idx,
				input logic [31:0] data);
			case (idx)
				REG_COS:      cos_q = data;
				REG_SIN:      sin_q = data;
				REG_CENTER_X: center_q[0] = data;
				REG_CENTER_Y: center_q[1] = data;
				REG_CENTER_Z: center_q[2] = data;
				REG_AXIS_X:   axis_q[0] = data;
				REG_AXIS_Y:   axis_q[1] = data;
				REG_AXIS_Z:   axis_q[2] = data;
				default:      return;
			endcase
			rebuild_matrix();
		endfunction

		// center + M*(p - center), exact until the final round and clamp
		function void note_point(input logic signed [31:0] px, input logic signed [31:0] py,
				input logic signed [31:0] pz, input logic last);
			logic signed [31:0]  p [3];
			logic signed [31:0]  q [3];
			logic signed [127:0] d [3];
			logic signed [127:0] acc;
			rotated_point_t      want;
			bit                  clip;
			bit                  any_clip;
			p = '{px, py, pz};
			any_clip = 1'b0;
			for (int k = 0; k < 3; k++)
				d[k] = wide(p[k]) - wide(center_q[k]);
			for (int r = 0; r < 3; r++) begin
				acc = wide(center_q[r]) <<< FRAC;
				for (int k = 0; k < 3; k++)
					acc = acc + wide(mat[r * 3 + k]) * d[k];
				q[r] = round_clamp(acc, clip);
				any_clip |= clip;
			end
			want.x = q[0];
			want.y = q[1];
			want.z = q[2];
			want.last = last;
			want.sat = any_clip;
			rotated_q.insert(rotated_q.size(), want);
		endfunction

		function void compare_field(input string name, input logic signed [31:0] want,
				input logic signed [31:0] got);
			if (got !== want) begin
				$error("%s mismatch: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_point(input logic signed [31:0] x, input logic signed [31:0] y,
				input logic signed [31:0] z, input logic last, input logic sat);
			rotated_point_t want;
			if (rotated_q.size() == 0) begin
				$error("output beat with no point pending: px_out=%0d py_out=%0d pz_out=%0d",
					x, y, z);
				errors++;
				return;
			end
			want = rotated_q.pop_front();
			compare_field("px_out", want.x, x);
			compare_field("py_out", want.y, y);
			compare_field("pz_out", want.z, z);
			compare_field("last_point_out", 32'(want.last), 32'(last));
			compare_field("saturated", 32'(want.sat), 32'(sat));
		endfunction

		function int pending();
			return rotated_q.size();
		endfunction
	endclass

endpackage

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for axis_angle_point_rotation_unit.
// Depends on aapr_pkg, point_rotation_check_pkg and the RTL of the unit.
module tb_top;
	import aapr_pkg::*;
	import point_rotation_check_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;   // cycles without any beat or write
	localparam int DRAIN_CYCLES   = 12;     // five pipeline stages plus margin
	localparam int RANDOM_POINTS  = 1450;

	localparam logic signed [31:0] C_MAX   = 32'sh7fff_ffff;
	localparam logic signed [31:0] C_MIN   = 32'sh8000_0000;
	localparam logic signed [31:0] ONE_Q16 = 32'sh0001_0000;
	localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;
	// indexes 8..15 are decoded as no register at all
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_BASE = 4'd8;

	typedef enum {SINK_OPEN, SINK_COIN, SINK_PATTERN, SINK_CHOKE} sink_mode_t;
	typedef enum {SET_TRIG, SET_PLANAR, SET_RAW, SET_CORNER} setting_kind_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]    cfg_index = '0;
	logic [31:0]             cfg_data = '0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic signed [31:0]      px_in = '0;
	logic signed [31:0]      py_in = '0;
	logic signed [31:0]      pz_in = '0;
	logic                    last_point_in = 1'b0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic signed [31:0]      px_out;
	logic signed [31:0]      py_out;
	logic signed [31:0]      pz_out;
	logic                    last_point_out;
	logic                    saturated;

	rotation_scoreboard      sb;
	int unsigned             quiet_cycles = 0;
	int                      burst_left = 0;   // beats left before the next gap
	int                      set_left = 0;     // points left before a last-point mark

	sink_mode_t              sink_mode = SINK_OPEN;
	int                      sink_left = 0;
	logic [7:0]              sink_pat = 8'h5a;

	axis_angle_point_rotation_unit u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.px_in          (px_in),
		.py_in          (py_in),
		.pz_in          (pz_in),
		.last_point_in  (last_point_in),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.px_out         (px_out),
		.py_out         (py_out),
		.pz_out         (pz_out),
		.last_point_out (last_point_out),
		.saturated      (saturated)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Output side: check every accepted beat, then pick out_ready for the next
	// edge. The sink switches between its modes at random so that stalls
	// land on every pipeline stage.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_point(px_out, py_out, pz_out, last_point_out, saturated);
		if (sink_left == 0) begin
			sink_mode = sink_mode_t'($urandom_range(0, 3));
			sink_left = $urandom_range(20, 200);
			sink_pat = 8'($urandom_range(1, 255));
		end
		sink_left--;
		sink_pat = {sink_pat[6:0], sink_pat[7]};
		case (sink_mode)
			SINK_OPEN:    out_ready <= 1'b1;
			SINK_COIN:    out_ready <= 1'($urandom_range(0, 1));
			SINK_PATTERN: out_ready <= sink_pat[0];
			default:      out_ready <= ($urandom_range(0, 5) == 0);
		endcase
	end

	// Watchdog: any beat on either side or a register write counts as progress.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Hold one point on the bus until it is taken. Beats go out in bursts;
	// after each burst the sender drops valid for a random gap.
	task automatic send_point(input logic signed [31:0] x, input logic signed [31:0] y,
			input logic signed [31:0] z, input logic last);
		in_valid <= 1'b1;
		px_in <= x;
		py_in <= y;
		pz_in <= z;
		last_point_in <= last;
		do
			@(posedge clk);
		while (in_ready !== 1'b1);
		sb.note_point(x, y, z, last);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 5) == 0) ? 150 : $urandom_range(0, 40);
		end
	endtask

	// Stop sending and let every pending point come out of the pipe.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Leaves cfg_wr_en high; the caller drops it after the last write.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		sb.write_register(idx, data);
		@(posedge clk);
	endtask

	// Program all eight registers back to back once the pipe is empty. A write
	// to an unmapped index is slipped in at a random spot most of the time.
	task automatic program_rotation(input logic signed [31:0] c, input logic signed [31:0] s,
			input logic signed [31:0] cx, input logic signed [31:0] cy,
			input logic signed [31:0] cz, input logic signed [31:0] ax,
			input logic signed [31:0] ay, input logic signed [31:0] az);
		logic [CFG_IDX_W-1:0] order [8];
		logic signed [31:0]   vals [8];
		int                   junk_at;
		order = '{REG_COS, REG_SIN, REG_CENTER_X, REG_CENTER_Y, REG_CENTER_Z,
			REG_AXIS_X, REG_AXIS_Y, REG_AXIS_Z};
		vals = '{c, s, cx, cy, cz, ax, ay, az};
		junk_at = $urandom_range(0, 8);
		wait_idle();
		for (int k = 0; k < 8; k++) begin
			if (k == junk_at)
				write_reg(REG_UNUSED_BASE + 4'($urandom_range(0, 7)), $urandom);
			write_reg(order[k], vals[k]);
		end
		cfg_wr_en <= 1'b0;
	endtask

	// Full-scale corners, the origin and one point of unit steps; both last-point values.
	task automatic send_corner_points();
		send_point(0, 0, 0, 1'b0);
		send_point(C_MAX, C_MAX, C_MAX, 1'b1);
		send_point(C_MIN, C_MIN, C_MIN, 1'b0);
		send_point(C_MAX, C_MIN, 0, 1'b1);
		send_point(ONE_Q16, -ONE_Q16, -1, 1'b0);
		send_point(C_MIN, C_MAX, ONE_Q16, 1'b1);
	endtask

	function automatic logic signed [31:0] to_q30(input real v);
		longint q;
		q = longint'(v * 1073741824.0);
		if (q > 64'sd1073741824)
			q = 64'sd1073741824;
		if (q < -64'sd1073741824)
			q = -64'sd1073741824;
		return q[31:0];
	endfunction

	function automatic real rand_unit();
		return real'($urandom_range(0, 2000000)) / 1.0e6 - 1.0;
	endfunction

	// anywhere in [-1.0, 1.0] in Q2.30
	function automatic logic signed [31:0] rand_coef();
		longint q;
		q = longint'($urandom_range(0, 32'h8000_0000)) - 64'sd1073741824;
		return q[31:0];
	endfunction

	// one of -1.0, 0, +1.0
	function automatic logic signed [31:0] corner_coef();
		longint q;
		q = (longint'($urandom_range(0, 2)) - 64'sd1) * 64'sd1073741824;
		return q[31:0];
	endfunction

	function automatic logic signed [31:0] rand_center();
		int unsigned pick;
		pick = $urandom_range(0, 7);
		if (pick < 2)
			return 0;
		if (pick < 5)
			return $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
		if (pick < 7)
			return $urandom;
		return (pick[0] ^ $urandom_range(0, 1)) ? C_MAX : C_MIN;
	endfunction

	// Mostly points near the center; the rest are
	// full-range words and corners, which drive the saturation path.
	function automatic logic signed [31:0] rand_coord(input logic signed [31:0] center);
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick < 6)
			return center + ($signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000);
		if (pick < 9)
			return $urandom;
		case ($urandom_range(0, 3))
			0:       return C_MAX;
			1:       return C_MIN;
			2:       return 0;
			default: return -1;
		endcase
	endfunction

	// last-point marks close sets of random length
	function automatic logic next_last();
		if (set_left == 0) begin
			set_left = $urandom_range(0, 30);
			return 1'b1;
		end
		set_left--;
		return 1'b0;
	endfunction

	task automatic program_random_setting();
		real                ang;
		real                ux;
		real                uy;
		real                uz;
		real                norm;
		logic signed [31:0] c;
		logic signed [31:0] s;
		logic signed [31:0] ax;
		logic signed [31:0] ay;
		logic signed [31:0] az;
		setting_kind_t      kind;
		kind = setting_kind_t'($urandom_range(0, 3));
		ang = real'($urandom_range(0, 62831853)) / 1.0e7;
		ux = rand_unit();
		uy = rand_unit();
		uz = rand_unit();
		norm = $sqrt(ux * ux + uy * uy + uz * uz);
		if (norm < 0.01) begin
			ux = 0.0;
			uy = 0.0;
			uz = 1.0;
			norm = 1.0;
		end
		c = to_q30($cos(ang));
		s = to_q30($sin(ang));
		ax = to_q30(ux / norm);
		ay = to_q30(uy / norm);
		az = to_q30(uz / norm);
		case (kind)
			SET_PLANAR: begin
				// 2D mode: z passes through untouched
				ax = 0;
				ay = 0;
				az = ONE_Q30;
			end
			SET_RAW: begin
				// arbitrary coefficients, no unit axis, no trig identity
				c = rand_coef();
				s = rand_coef();
				ax = rand_coef();
				ay = rand_coef();
				az = rand_coef();
			end
			SET_CORNER: begin
				c = corner_coef();
				s = corner_coef();
				ax = corner_coef();
				ay = corner_coef();
				az = corner_coef();
			end
			default: ;
		endcase
		program_rotation(c, s, rand_center(), rand_center(), rand_center(), ax, ay, az);
	endtask

	initial begin
		int sent;
		int n;
		sb = new();
		sent = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: the reset matrix (identity), a quarter turn in the plane
		// that clips at the corners, a half turn about x around a center at
		// full scale, and a non-unit axis with cos = sin = -1 that saturates
		// the matrix entries themselves.
		send_corner_points();
		program_rotation(0, ONE_Q30, 0, 0, 0, 0, 0, ONE_Q30);
		send_corner_points();
		program_rotation(-ONE_Q30, 0, C_MAX, C_MIN, ONE_Q16, ONE_Q30, 0, 0);
		send_corner_points();
		program_rotation(-ONE_Q30, -ONE_Q30, C_MIN, C_MAX, C_MIN, ONE_Q30, ONE_Q30, -ONE_Q30);
		send_corner_points();

		// Random: a fresh setting every phase, then a run of points.
		while (sent < RANDOM_POINTS) begin
			program_random_setting();
			n = $urandom_range(40, 160);
			for (int k = 0; k < n; k++) begin
				send_point(rand_coord(sb.center_q[0]), rand_coord(sb.center_q[1]),
					rand_coord(sb.center_q[2]), next_last());
				sent++;
			end
		end

		wait_idle();
		if (sb.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
